FILE: design/cpt_pkg.sv
// package for the circular prime tester: microcode layout, program and width helpers
`timescale 1ns / 1ps
`default_nettype none

package cpt_pkg;

    localparam int IN_BITS = 20;
    localparam int PC_W    = 5;
    localparam int OP_W    = 4;
    localparam int COND_W  = 4;

    // micro-operations
    localparam logic [OP_W-1:0] OP_WAIT   = 4'd0;
    localparam logic [OP_W-1:0] OP_NOP    = 4'd1;
    localparam logic [OP_W-1:0] OP_DIVT   = 4'd2;
    localparam logic [OP_W-1:0] OP_SINIT  = 4'd3;
    localparam logic [OP_W-1:0] OP_SMUL   = 4'd4;
    localparam logic [OP_W-1:0] OP_CINIT  = 4'd5;
    localparam logic [OP_W-1:0] OP_TINIT  = 4'd6;
    localparam logic [OP_W-1:0] OP_DIVD   = 4'd7;
    localparam logic [OP_W-1:0] OP_STEP   = 4'd8;
    localparam logic [OP_W-1:0] OP_ROTDIV = 4'd9;
    localparam logic [OP_W-1:0] OP_ROT    = 4'd10;
    localparam logic [OP_W-1:0] OP_PASS   = 4'd11;
    localparam logic [OP_W-1:0] OP_FAIL   = 4'd12;

    // jump conditions
    localparam logic [COND_W-1:0] C_NEVER  = 4'd0;
    localparam logic [COND_W-1:0] C_ALWAYS = 4'd1;
    localparam logic [COND_W-1:0] C_NOIN   = 4'd2;
    localparam logic [COND_W-1:0] C_TMPZ   = 4'd3;
    localparam logic [COND_W-1:0] C_CNTLE1 = 4'd4;
    localparam logic [COND_W-1:0] C_LT2    = 4'd5;
    localparam logic [COND_W-1:0] C_SQGT   = 4'd6;
    localparam logic [COND_W-1:0] C_REMZ   = 4'd7;
    localparam logic [COND_W-1:0] C_CNTZ   = 4'd8;

    // program addresses
    localparam logic [PC_W-1:0] A_WAIT   = 5'd0;
    localparam logic [PC_W-1:0] A_DCHK   = 5'd1;
    localparam logic [PC_W-1:0] A_DIVT   = 5'd2;
    localparam logic [PC_W-1:0] A_SINIT  = 5'd3;
    localparam logic [PC_W-1:0] A_SCHK   = 5'd4;
    localparam logic [PC_W-1:0] A_SMUL   = 5'd5;
    localparam logic [PC_W-1:0] A_CINIT  = 5'd6;
    localparam logic [PC_W-1:0] A_TINIT  = 5'd7;
    localparam logic [PC_W-1:0] A_SQCHK  = 5'd8;
    localparam logic [PC_W-1:0] A_DIVD   = 5'd9;
    localparam logic [PC_W-1:0] A_REMCHK = 5'd10;
    localparam logic [PC_W-1:0] A_STEP   = 5'd11;
    localparam logic [PC_W-1:0] A_CNTCHK = 5'd12;
    localparam logic [PC_W-1:0] A_ROTDIV = 5'd13;
    localparam logic [PC_W-1:0] A_ROT    = 5'd14;
    localparam logic [PC_W-1:0] A_PASS   = 5'd15;
    localparam logic [PC_W-1:0] A_FAIL   = 5'd16;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } t_uword;

    function automatic t_uword f_ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            A_WAIT:   w = '{op: OP_WAIT,   cond: C_NOIN,   target: A_WAIT};
            A_DCHK:   w = '{op: OP_NOP,    cond: C_TMPZ,   target: A_SINIT};
            A_DIVT:   w = '{op: OP_DIVT,   cond: C_ALWAYS, target: A_DCHK};
            A_SINIT:  w = '{op: OP_SINIT,  cond: C_NEVER,  target: A_WAIT};
            A_SCHK:   w = '{op: OP_NOP,    cond: C_CNTLE1, target: A_CINIT};
            A_SMUL:   w = '{op: OP_SMUL,   cond: C_ALWAYS, target: A_SCHK};
            A_CINIT:  w = '{op: OP_CINIT,  cond: C_NEVER,  target: A_WAIT};
            A_TINIT:  w = '{op: OP_TINIT,  cond: C_LT2,    target: A_FAIL};
            A_SQCHK:  w = '{op: OP_NOP,    cond: C_SQGT,   target: A_CNTCHK};
            A_DIVD:   w = '{op: OP_DIVD,   cond: C_NEVER,  target: A_WAIT};
            A_REMCHK: w = '{op: OP_NOP,    cond: C_REMZ,   target: A_FAIL};
            A_STEP:   w = '{op: OP_STEP,   cond: C_ALWAYS, target: A_SQCHK};
            A_CNTCHK: w = '{op: OP_NOP,    cond: C_CNTZ,   target: A_PASS};
            A_ROTDIV: w = '{op: OP_ROTDIV, cond: C_NEVER,  target: A_WAIT};
            A_ROT:    w = '{op: OP_ROT,    cond: C_ALWAYS, target: A_TINIT};
            A_PASS:   w = '{op: OP_PASS,   cond: C_ALWAYS, target: A_WAIT};
            A_FAIL:   w = '{op: OP_FAIL,   cond: C_ALWAYS, target: A_WAIT};
            default:  w = '{op: OP_NOP,    cond: C_ALWAYS, target: A_WAIT};
        endcase
        return w;
    endfunction

    // decimal digits of the largest value that fits in the given bits
    function automatic int f_digits(input int bits);
        logic [63:0] v;
        int          k;
        v = (64'd1 << bits) - 64'd1;
        k = 0;
        while (v != 64'd0) begin
            k = k + 1;
            v = v / 64'd10;
        end
        return k;
    endfunction

    // bits needed for any value of the given number of digits
    function automatic int f_work_bits(input int digits);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < digits; i++) begin
            p = p * 64'd10;
        end
        return $clog2(p);
    endfunction

endpackage

`default_nettype wire

FILE: design/circular_prime_test_core.sv
// circular prime tester: microcoded sequencer over a shared shift-subtract divider
//
//  channel  dir  fields (tdata, low bit up)         accept
//  s        in   number[19:0], 4'b0                 i_s_tvalid & o_s_tready
//  m        out  is_circular_prime[0], 7'b0         o_m_tvalid & i_m_tready
//
// every division is done bit by bit in the one divider, over W bits (W = 24 at the default width)
// an item runs (k+1) prime tests, k digits, each with about sqrt(v) trial divisors
// up to eight full tests for seven-digit values; composites leave early
// a new item is taken only at the wait step; a waiting result does not block it
// synchronous active-low reset clears the step counter, divider and output flag
`timescale 1ns / 1ps
`default_nettype none

module circular_prime_test_core
    import cpt_pkg::*;
#(
    parameter int VALUE_BITS = 20
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // number[19:0], zero pad
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata    // is_circular_prime[0], zero pad
);

    localparam int EFF_BITS = (VALUE_BITS < IN_BITS) ? VALUE_BITS : IN_BITS;
    localparam int DIG      = f_digits(EFF_BITS);
    localparam int W        = f_work_bits(DIG);
    localparam int K_W      = $clog2(DIG + 1);
    localparam int BIT_W    = $clog2(W);
    localparam int SQ_W     = W + 2;
    localparam logic [IN_BITS-1:0] IN_MASK = IN_BITS'((64'd1 << EFF_BITS) - 64'd1);
    localparam logic [W-1:0]       TEN     = W'(10);

    logic [PC_W-1:0]  r_pc, n_pc;
    logic [W-1:0]     r_val, n_val;
    logic [W-1:0]     r_tmp, n_tmp;
    logic [K_W-1:0]   r_k, n_k;
    logic [K_W-1:0]   r_cnt, n_cnt;
    logic [W-1:0]     r_scale, n_scale;
    logic [W-1:0]     r_d, n_d;
    logic [SQ_W-1:0]  r_sq, n_sq;
    logic [W-1:0]     r_dq, n_dq;
    logic [W-1:0]     r_rem, n_rem;
    logic [W-1:0]     r_dor, n_dor;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic             r_busy, n_busy;
    logic             r_out_valid, n_out_valid;
    logic             r_out_bit, n_out_bit;

    t_uword           uw;
    logic             s_acc;
    logic             m_acc;
    logic             div_op;
    logic             div_done;
    logic [W:0]       div_t;
    logic             div_ge;
    logic [W-1:0]     div_rem_n;
    logic [W-1:0]     div_dq_n;
    logic [W+3:0]     rot_sum;
    logic             cond_hit;
    logic             stall;
    logic             res_op;

    assign uw         = f_ucode(r_pc);
    assign o_s_tready = (r_pc == A_WAIT);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_out_bit};
    assign m_acc      = r_out_valid && i_m_tready;

    // one restoring step of the divider
    assign div_t     = {r_rem, r_dq[W-1]};
    assign div_ge    = (div_t >= {1'b0, r_dor});
    assign div_rem_n = div_ge ? W'(div_t - {1'b0, r_dor}) : div_t[W-1:0];
    assign div_dq_n  = {r_dq[W-2:0], div_ge};
    assign div_op    = (uw.op == OP_DIVT) || (uw.op == OP_DIVD) || (uw.op == OP_ROTDIV);
    assign div_done  = r_busy && (r_bit == BIT_W'(W - 1));

    // rotation: last digit times 10^(k-1) plus the quotient
    assign rot_sum = (W+4)'(r_rem[3:0]) * (W+4)'(r_scale) + (W+4)'(r_dq);

    assign res_op = (uw.op == OP_PASS) || (uw.op == OP_FAIL);
    assign stall  = (div_op && !div_done) || (res_op && r_out_valid && !i_m_tready);

    always_comb begin
        unique case (uw.cond)
            C_NEVER:  cond_hit = 1'b0;
            C_ALWAYS: cond_hit = 1'b1;
            C_NOIN:   cond_hit = !s_acc;
            C_TMPZ:   cond_hit = (r_tmp == '0);
            C_CNTLE1: cond_hit = (r_cnt <= K_W'(1));
            C_LT2:    cond_hit = (r_val < W'(2));
            C_SQGT:   cond_hit = (r_sq > SQ_W'(r_val));
            C_REMZ:   cond_hit = (r_rem == '0);
            C_CNTZ:   cond_hit = (r_cnt == '0);
            default:  cond_hit = 1'b0;
        endcase
    end

    always_comb begin
        n_pc        = r_pc;
        n_val       = r_val;
        n_tmp       = r_tmp;
        n_k         = r_k;
        n_cnt       = r_cnt;
        n_scale     = r_scale;
        n_d         = r_d;
        n_sq        = r_sq;
        n_dq        = r_dq;
        n_rem       = r_rem;
        n_dor       = r_dor;
        n_bit       = r_bit;
        n_busy      = r_busy;
        n_out_valid = m_acc ? 1'b0 : r_out_valid;
        n_out_bit   = r_out_bit;

        if (!stall) begin
            n_pc = cond_hit ? uw.target : r_pc + PC_W'(1);
        end

        if (div_op) begin
            if (!r_busy) begin
                n_busy = 1'b1;
                n_bit  = '0;
                n_rem  = '0;
                n_dq   = (uw.op == OP_DIVT) ? r_tmp : r_val;
                n_dor  = (uw.op == OP_DIVD) ? r_d : TEN;
            end else begin
                n_dq  = div_dq_n;
                n_rem = div_rem_n;
                n_bit = r_bit + BIT_W'(1);
                if (div_done) begin
                    n_busy = 1'b0;
                end
            end
        end

        unique case (uw.op)
            OP_WAIT: begin
                if (s_acc) begin
                    n_val = W'(i_s_tdata[IN_BITS-1:0] & IN_MASK);
                    n_tmp = W'(i_s_tdata[IN_BITS-1:0] & IN_MASK);
                    n_k   = '0;
                end
            end
            OP_DIVT: begin
                if (div_done) begin
                    n_tmp = div_dq_n;
                    n_k   = r_k + K_W'(1);
                end
            end
            OP_SINIT: begin
                n_scale = W'(1);
                n_cnt   = r_k;
            end
            OP_SMUL: begin
                n_scale = W'({r_scale, 3'b0} + {r_scale, 1'b0});
                n_cnt   = r_cnt - K_W'(1);
            end
            OP_CINIT: n_cnt = r_k;
            OP_TINIT: begin
                n_d  = W'(2);
                n_sq = SQ_W'(4);
            end
            OP_STEP: begin
                n_sq = r_sq + SQ_W'({r_d, 1'b1});
                n_d  = r_d + W'(1);
            end
            OP_ROT: begin
                n_val = rot_sum[W-1:0];
                n_cnt = r_cnt - K_W'(1);
            end
            OP_PASS, OP_FAIL: begin
                if (!stall) begin
                    n_out_valid = 1'b1;
                    n_out_bit   = (uw.op == OP_PASS);
                end
            end
            OP_NOP, OP_DIVD, OP_ROTDIV: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= A_WAIT;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
        r_val     <= n_val;
        r_tmp     <= n_tmp;
        r_k       <= n_k;
        r_cnt     <= n_cnt;
        r_scale   <= n_scale;
        r_d       <= n_d;
        r_sq      <= n_sq;
        r_dq      <= n_dq;
        r_rem     <= n_rem;
        r_dor     <= n_dor;
        r_bit     <= n_bit;
        r_out_bit <= n_out_bit;
    end

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= A_FAIL)
        else $error("step counter left the program");

    a_busy_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> div_op)
        else $error("divider busy outside a division step");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_pc == A_DCHK) && !r_busy)
        else $error("accepted item did not start digit count");

    a_result_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_op && !stall) |-> (!r_out_valid || i_m_tready))
        else $error("result written over a waiting item");

    a_trial_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == A_DIVD && !r_busy) |-> (r_d >= W'(2)))
        else $error("trial divisor below two");

endmodule

`default_nettype wire

FILE: test/tb_circular_prime_test_core.sv
// testbench for circular_prime_test_core: directed and random numbers against a predictor
`timescale 1ns / 1ps

module tb_circular_prime_test_core;
    import cpt_pkg::*;

    localparam int NUM_BITS       = IN_BITS;
    localparam int DIRECTED_ROWS  = 25;
    localparam int RANDOM_ITEMS   = 63;
    localparam int PRESSURE_ITEMS = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3_000_000;

    typedef struct packed {
        logic [NUM_BITS-1:0] number;
        logic                known;
        logic                verdict;
    } t_row;

    typedef struct {
        logic [NUM_BITS-1:0] number;
        logic                verdict;
    } t_verdict;

    localparam t_row ROWS [DIRECTED_ROWS] = '{
        '{20'd0,       1'b1, 1'b0},
        '{20'd1,       1'b1, 1'b0},
        '{20'd2,       1'b1, 1'b1},
        '{20'd3,       1'b1, 1'b1},
        '{20'd4,       1'b1, 1'b0},
        '{20'd5,       1'b1, 1'b1},
        '{20'd7,       1'b1, 1'b1},
        '{20'd11,      1'b0, 1'b0},
        '{20'd19,      1'b0, 1'b0},
        '{20'd97,      1'b0, 1'b0},
        '{20'd101,     1'b0, 1'b0},
        '{20'd103,     1'b0, 1'b0},
        '{20'd113,     1'b0, 1'b0},
        '{20'd199,     1'b0, 1'b0},
        '{20'd991,     1'b0, 1'b0},
        '{20'd1000,    1'b1, 1'b0},
        '{20'd9377,    1'b0, 1'b0},
        '{20'd11939,   1'b0, 1'b0},
        '{20'd99371,   1'b0, 1'b0},
        '{20'd999331,  1'b0, 1'b0},
        '{20'd524288,  1'b1, 1'b0},
        '{20'd699050,  1'b1, 1'b0},
        '{20'd349525,  1'b1, 1'b0},
        '{20'd1048575, 1'b1, 1'b0},
        '{20'd1048573, 1'b0, 1'b0}
    };

    localparam int SHORT_CIRCULAR [33] = '{
        2, 3, 5, 7, 11, 13, 17, 31, 37, 71, 73, 79, 97, 113, 131, 197, 199,
        311, 337, 373, 719, 733, 919, 971, 991, 1193, 1931, 3119, 3779,
        7793, 7937, 9311, 9377
    };

    localparam int FIVE_DIGIT_CIRCULAR [10] = '{
        11939, 19391, 19937, 37199, 39119, 71993, 91193, 93719, 93911, 99371
    };

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata  = '0;   // number[19:0], zero pad
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;         // is_circular_prime[0], zero pad

    t_verdict verdicts_due [$];
    int       mismatches   = 0;
    int       tested       = 0;
    int       results_seen = 0;
    int       circular_seen = 0;
    int       quiet_cycles = 0;
    int       hold_left    = 0;
    logic     hold_start   = 1'b0;
    logic     calm         = 1'b0;

    circular_prime_test_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic trial_prime(input logic [63:0] v);
        logic [63:0] d;
        if (v < 64'd2) return 1'b0;
        for (d = 64'd2; d * d <= v; d++) begin
            if (v % d == 64'd0) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic circular_verdict(input logic [NUM_BITS-1:0] number);
        logic [63:0] v;
        logic [63:0] rest;
        logic [63:0] scale;
        int          digits;
        v      = 64'(number);
        rest   = v;
        digits = 0;
        while (rest != 64'd0) begin
            digits++;
            rest = rest / 64'd10;
        end
        if (!trial_prime(v)) return 1'b0;
        scale = 64'd1;
        for (int r = 1; r < digits; r++) scale = scale * 64'd10;
        for (int r = 0; r < digits; r++) begin
            v = (v % 64'd10) * scale + v / 64'd10;
            if (!trial_prime(v)) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [NUM_BITS-1:0] random_number();
        int pick;
        int place;
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            return NUM_BITS'(SHORT_CIRCULAR[$urandom_range(0, 32)]);
        end else if (pick < 25) begin
            return NUM_BITS'(FIVE_DIGIT_CIRCULAR[$urandom_range(0, 9)]);
        end else if (pick < 50) begin
            return NUM_BITS'($urandom_range(0, 9999));
        end else if (pick < 60) begin
            // inner zero digits, so rotations come out shorter
            case ($urandom_range(1, 4))
                1:       place = 100;
                2:       place = 1000;
                3:       place = 10000;
                default: place = 100000;
            endcase
            return NUM_BITS'($urandom_range(1, 9) * place + $urandom_range(1, 9));
        end
        return NUM_BITS'($urandom());
    endfunction

    task automatic report_mismatch(input string what, input logic [NUM_BITS-1:0] number,
                                   input logic got, input logic want);
        $display("mismatch: %s, number %0d, got %b, expected %b", what, number, got, want);
        mismatches++;
    endtask

    task automatic offer_number(input logic [NUM_BITS-1:0] number, input logic known,
                                input logic verdict);
        int       gap;
        t_verdict due;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 15) gap = $urandom_range(1, 8);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0, number};
        do @(posedge i_clk); while (!o_s_tready);
        due.number  = number;
        due.verdict = known ? verdict : circular_verdict(number);
        verdicts_due.push_back(due);
        tested++;
    endtask

    task automatic drain_verdicts();
        i_s_tvalid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_verdict due;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            hold_left  <= 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                results_seen++;
                if (o_m_tdata[0]) circular_seen++;
                if (verdicts_due.size() == 0) begin
                    report_mismatch("result with nothing pending", 'x, o_m_tdata[0], 1'bx);
                end else begin
                    due = verdicts_due.pop_front();
                    if (o_m_tdata[0] !== due.verdict) begin
                        report_mismatch("is_circular_prime", due.number, o_m_tdata[0],
                                        due.verdict);
                    end
                end
            end
            if (hold_start) begin
                hold_left  <= HOLD_CYCLES;
                i_m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left  <= hold_left - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= calm || ($urandom_range(0, 99) >= 15);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            offer_number(ROWS[i].number, ROWS[i].known, ROWS[i].verdict);
        end
        drain_verdicts();

        // output held off while quick even numbers pile up behind it
        calm       <= 1'b1;
        hold_start <= 1'b1;
        @(posedge i_clk);
        hold_start <= 1'b0;
        for (int i = 0; i < PRESSURE_ITEMS; i++) begin
            offer_number(NUM_BITS'($urandom_range(0, 49) * 2), 1'b0, 1'b0);
        end
        drain_verdicts();
        calm <= 1'b0;
        @(posedge i_clk);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 25) calm <= 1'b1;
            if (i == 45) calm <= 1'b0;
            offer_number(random_number(), 1'b0, 1'b0);
        end
        drain_verdicts();
        repeat (200) @(posedge i_clk);

        $display("summary: %0d numbers tested, %0d results, %0d circular primes",
                 tested, results_seen, circular_seen);
        $display("covered: extremes, zero digits, long primes, a held-off output, random numbers");
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/cpt_pkg.sv
design/circular_prime_test_core.sv
test/tb_circular_prime_test_core.sv
